[sv/sequence_window_checker_macros.svh]
// ----------------------------------------------------------------------------
// sequence_window_checker_macros
// assertion macros used by the sequence window checker controller
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_WINDOW_CHECKER_MACROS_SVH
`define SEQUENCE_WINDOW_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SQW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SQW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SQW_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define SQW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[sv/sqw_pkg.sv]
// ----------------------------------------------------------------------------
// sqw_pkg
// types and constants of the sequence window checker
// ----------------------------------------------------------------------------
package sqw_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;
  localparam int unsigned SEQ_W            = 32;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REORDER = 2'd1;
  localparam logic [1:0] STATUS_MISSED  = 2'd2;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_number;
    logic [SEQ_W-1:0] increment;
  } sqw_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [SEQ_W-1:0] gap;
  } sqw_out_t;

endpackage

[sv/sqw_stream_if.sv]
// ----------------------------------------------------------------------------
// sqw_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface sqw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/sqw_ring_ram.sv]
// ----------------------------------------------------------------------------
// sqw_ring_ram
// history ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module sqw_ring_ram #(
  parameter int unsigned DEPTH = sqw_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [sqw_pkg::SEQ_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [sqw_pkg::SEQ_W-1:0] rdata_o
);
  import sqw_pkg::*;

  logic [SEQ_W-1:0] mem [DEPTH];
  logic [SEQ_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sqw_mod_unit.sv]
// ----------------------------------------------------------------------------
// sqw_mod_unit
// remainder of a 32-bit value by the window depth, reciprocal multiply through
// a registered operand, quotient estimate and remainder
// ----------------------------------------------------------------------------
module sqw_mod_unit #(
  parameter int unsigned DEPTH = sqw_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sqw_pkg::SEQ_W-1:0] dividend_i,
  output logic                      done_o,
  output logic [AW-1:0]             rem_o
);
  import sqw_pkg::*;

  // quotient estimate floor(x * RECIP / 2^SH) is exact or one low
  localparam int unsigned      SH      = SEQ_W - 1 + AW;
  localparam logic [63:0]      RECIP_W = (64'd1 << SH) / 64'(DEPTH);
  localparam logic [SEQ_W-1:0] RECIP   = RECIP_W[SEQ_W-1:0];

  logic               s1_q;
  logic               s2_q;
  logic               done_q, done_d;
  logic [SEQ_W-1:0]   x_q;
  logic [2*SEQ_W-1:0] prod;
  logic [AW:0]        q_lo_q;
  logic [AW:0]        x_lo_q;
  logic [AW:0]        r_raw;
  logic [AW-1:0]      rem_q, rem_d;

  // only the low quotient bits matter, the remainder is below twice the depth
  assign prod   = (2*SEQ_W)'(x_q) * (2*SEQ_W)'(RECIP);
  assign r_raw  = x_lo_q - (AW+1)'(q_lo_q * (AW+1)'(DEPTH));
  assign rem_d  = (r_raw >= (AW+1)'(DEPTH)) ? AW'(r_raw - (AW+1)'(DEPTH))
                                            : r_raw[AW-1:0];
  assign done_d = start_i ? 1'b0 : (s2_q ? 1'b1 : done_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
    end
    if (s1_q) begin
      q_lo_q <= prod[SH +: AW+1];
      x_lo_q <= x_q[AW:0];
    end
    if (s2_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[sv/sqw_ctrl.sv]
// ----------------------------------------------------------------------------
// sqw_ctrl
// sequencer: ring clear, window scan, index update, write-back and result
// ----------------------------------------------------------------------------
`include "sequence_window_checker_macros.svh"

module sqw_ctrl #(
  parameter int unsigned WINDOW_DEPTH = sqw_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned AW           = $clog2(WINDOW_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  sqw_stream_if.sink                in_i,
  sqw_stream_if.source              out_o,
  output logic                      ram_we_o,
  output logic [AW-1:0]             ram_waddr_o,
  output logic [sqw_pkg::SEQ_W-1:0] ram_wdata_o,
  output logic                      ram_re_o,
  output logic [AW-1:0]             ram_raddr_o,
  input  logic [sqw_pkg::SEQ_W-1:0] ram_rdata_i,
  output logic                      mod_start_o,
  output logic [sqw_pkg::SEQ_W-1:0] mod_dividend_o,
  input  logic                      mod_done_i,
  input  logic [AW-1:0]             mod_rem_i
);
  import sqw_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_GAP   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic [AW-1:0]    base_q, base_d;
  logic [AW-1:0]    raddr_q, raddr_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    new_idx_q, new_idx_d;
  logic             rd_pend_q, rd_pend_d;
  logic             first_q, first_d;
  logic             ok_q, ok_d;
  logic             hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  logic [SEQ_W-1:0] sn_q, sn_d;
  logic [SEQ_W-1:0] inc_q, inc_d;
  sqw_out_t         out_q, out_d;

  logic             in_fire;
  logic [SEQ_W-1:0] entry_sum;
  logic [AW:0]      idx_sum;
  logic [AW-1:0]    idx_wrap;
  logic [AW-1:0]    prev_idx;
  logic [1:0]       status;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign entry_sum  = ram_rdata_i + inc_q;
  assign idx_sum    = {1'b0, base_q} + {1'b0, mod_rem_i};
  assign idx_wrap   = (idx_sum >= (AW+1)'(WINDOW_DEPTH))
                    ? AW'(idx_sum - (AW+1)'(WINDOW_DEPTH)) : idx_sum[AW-1:0];
  assign prev_idx   = (new_idx_q == '0) ? AW'(WINDOW_DEPTH - 1) : new_idx_q - AW'(1);
  assign status     = ok_q ? STATUS_OK : (hit_q ? STATUS_REORDER : STATUS_MISSED);

  always_comb begin
    state_d        = state_q;
    clr_addr_d     = clr_addr_q;
    base_d         = base_q;
    raddr_d        = raddr_q;
    cnt_d          = cnt_q;
    new_idx_d      = new_idx_q;
    rd_pend_d      = 1'b0;
    first_d        = 1'b0;
    ok_d           = ok_q;
    hit_d          = hit_q;
    out_valid_d    = out_valid_q;
    sn_d           = sn_q;
    inc_d          = inc_q;
    out_d          = out_q;
    ram_we_o       = 1'b0;
    ram_waddr_o    = clr_addr_q;
    ram_wdata_o    = '0;
    ram_re_o       = 1'b0;
    ram_raddr_o    = raddr_q;
    mod_start_o    = in_fire;
    mod_dividend_o = in_i.data.increment;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // evaluate the entry read in the previous cycle
    if (rd_pend_q) begin
      if (first_q) begin
        ok_d = (entry_sum == sn_q);
      end
      if ((entry_sum == sn_q) || (ram_rdata_i > sn_q)) begin
        hit_d = 1'b1;
      end
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we_o   = 1'b1;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(WINDOW_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          sn_d    = in_i.data.seq_number;
          inc_d   = in_i.data.increment;
          raddr_d = base_q;
          cnt_d   = '0;
          hit_d   = 1'b0;
          ok_d    = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re_o  = 1'b1;
        rd_pend_d = 1'b1;
        first_d   = (cnt_q == '0);
        raddr_d   = (raddr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : raddr_q + AW'(1);
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == AW'(WINDOW_DEPTH - 2)) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mod_done_i && !rd_pend_q) begin
          new_idx_d = idx_wrap;
          state_d   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = new_idx_q;
        ram_wdata_o = sn_q;
        ram_re_o    = 1'b1;
        ram_raddr_o = prev_idx;
        base_d      = new_idx_q;
        state_d     = ST_GAP;
      end
      ST_GAP: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.status = status;
          out_d.gap    = sn_q - ram_rdata_i;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
      rd_pend_q   <= rd_pend_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q   <= raddr_d;
    new_idx_q <= new_idx_d;
    ok_q      <= ok_d;
    hit_q     <= hit_d;
    sn_q      <= sn_d;
    inc_q     <= inc_d;
    out_q     <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `SQW_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !in_i.ready, "input accepted during ring clear")
  `SQW_ASSERT_NXT(a_accept_starts_scan, clk_i, rst_ni, in_fire, state_q == ST_SCAN, "transfer did not start scan")
  `SQW_ASSERT_NOW(a_write_states, clk_i, rst_ni, ram_we_o, (state_q == ST_CLEAR) || (state_q == ST_WRITE), "ring written outside clear or write-back")
  `SQW_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_q, out_q.status != 2'd3, "undefined status code")

endmodule

[sv/sequence_window_checker.sv]
// ----------------------------------------------------------------------------
// sequence_window_checker
// packet sequence number checker against a ring of recent numbers
// ----------------------------------------------------------------------------
// After reset the ring is cleared one entry per cycle, with input ready low.
// Each transfer then scans WINDOW_DEPTH-1 ring entries through the single
// read port of the ring memory, one read per cycle, while a remainder unit
// using a reciprocal multiply reduces the increment to an index step. Once
// the last read is checked and the remainder is done, the new index is
// formed, then the number is written back and the previous entry read for
// the gap. A new transfer is taken only after the result of the last one is
// stored; a sink that still holds the previous result stalls the checker
// before that. A finished result waits in an output register while the next item runs.
module sequence_window_checker #(
  parameter int unsigned WINDOW_DEPTH = sqw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sqw_stream_if.sink    in_i,
  sqw_stream_if.source  out_o
);
  import sqw_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SEQ_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [SEQ_W-1:0] ram_rdata;
  logic             mod_start;
  logic [SEQ_W-1:0] mod_dividend;
  logic             mod_done;
  logic [AW-1:0]    mod_rem;

  sqw_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AW           (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .out_o          (out_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .mod_start_o    (mod_start),
    .mod_dividend_o (mod_dividend),
    .mod_done_i     (mod_done),
    .mod_rem_i      (mod_rem)
  );

  sqw_ring_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sqw_mod_unit #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

endmodule

[tb/tb_sequence_window_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequence_window_checker
// self-checking bench for the packet sequence window checker
// ----------------------------------------------------------------------------
// A short table of hand-picked packets covers reset contents, 32-bit wrap of
// number and increment, the unscanned entry just below the last index and
// each status code. 780 random packets follow: mostly streams that advance
// by a steady increment, with skips and repeats of older numbers mixed in,
// plus fully random noise. Each report is compared with its table row or
// with a model of the ring kept here. Both channels stall in random bursts
// except for the last 40 of every 200 random packets and the final 150.
module tb_sequence_window_checker;
  import sqw_pkg::*;

  localparam int unsigned DEPTH      = WINDOW_DEPTH_DEF;
  localparam int          N_DIRECTED = 19;
  localparam int          N_RANDOM   = 780;
  localparam int          N_CALM     = 150;

  typedef enum int {KIND_NEXT, KIND_SKIP, KIND_REPEAT, KIND_WILD} seq_kind_e;

  typedef struct {
    logic [31:0]        seq;
    logic [31:0]        inc;
    bit                 typed;
    logic [1:0]         status;
    logic signed [31:0] gap;
  } dir_row_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] gap;
  } report_t;

  logic clk_i;
  logic rst_ni;

  sqw_stream_if #(.payload_t(sqw_in_t))  in_if ();
  sqw_stream_if #(.payload_t(sqw_out_t)) out_if ();

  sequence_window_checker #(
    .WINDOW_DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // model of the ring
  logic [31:0] hist_ring [DEPTH];
  int unsigned hist_last;

  report_t expected_reports [$];
  bit      stalls_on;
  int      n_sent;
  int      n_checked;
  int      n_mismatch;
  int      n_ok;
  int      n_reorder;
  int      n_missed;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_OK,      32'sd0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, STATUS_MISSED,  -32'sd1},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, STATUS_OK,      32'sd1},
    '{32'h0000_0005, 32'hFFFF_FFFF, 1'b1, STATUS_MISSED,  32'sd5},
    '{32'h0000_0003, 32'h0000_0001, 1'b1, STATUS_REORDER, -32'sd2},
    '{32'h0000_0004, 32'h0000_0001, 1'b0, STATUS_OK,      32'sd0},
    '{32'h0000_0014, 32'h0000_0010, 1'b0, STATUS_OK,      32'sd0},
    '{32'h8000_0000, 32'h0000_0001, 1'b0, STATUS_OK,      32'sd0},
    '{32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK,      32'sd0},
    '{32'h7FFF_FFFF, 32'h8000_0010, 1'b0, STATUS_OK,      32'sd0},
    '{32'hFFFF_FFFE, 32'hAAAA_AAAA, 1'b0, STATUS_OK,      32'sd0},
    '{32'h5555_5555, 32'h5555_5555, 1'b0, STATUS_OK,      32'sd0},
    '{32'h1234_5678, 32'h0000_0007, 1'b0, STATUS_OK,      32'sd0},
    '{32'h1234_567F, 32'h0000_0007, 1'b0, STATUS_OK,      32'sd0},
    '{32'h1234_5686, 32'h0000_0007, 1'b0, STATUS_OK,      32'sd0},
    '{32'h1234_5681, 32'h0000_0007, 1'b0, STATUS_OK,      32'sd0},
    '{32'h1234_56A0, 32'h0000_0007, 1'b0, STATUS_OK,      32'sd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STATUS_OK,      32'sd0},
    '{32'h0000_0000, 32'h0000_0001, 1'b0, STATUS_OK,      32'sd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d sent, %0d reports checked", n_sent, n_checked);
    $display("RESULT: ERROR");
    $finish;
  end

  // status and gap for one packet, advancing the ring
  function automatic void window_check(input logic [31:0] sn, input logic [31:0] inc,
                                       output logic [1:0] status,
                                       output logic signed [31:0] gap);
    int unsigned base;
    int unsigned prev;
    logic [31:0] e;
    bit          hit;
    base = hist_last;
    hit  = 1'b0;
    for (int k = 0; k < DEPTH - 1; k++) begin
      e = hist_ring[(base + k) % DEPTH];
      if (e + inc == sn || e > sn) begin
        hit = 1'b1;
        break;
      end
    end
    if (hist_ring[base] + inc == sn) status = STATUS_OK;
    else if (hit)                    status = STATUS_REORDER;
    else                             status = STATUS_MISSED;
    hist_last = (base + inc % DEPTH) % DEPTH;
    hist_ring[hist_last] = sn;
    prev = (hist_last + DEPTH - 1) % DEPTH;
    gap  = sn - hist_ring[prev];
  endfunction

  task automatic send_packet(input logic [31:0] sn, input logic [31:0] inc, input bit typed,
                             input logic [1:0] t_status, input logic signed [31:0] t_gap);
    report_t            exp;
    logic [1:0]         p_status;
    logic signed [31:0] p_gap;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= '{seq_number: sn, increment: inc};
    do @(posedge clk_i); while (!in_if.ready);
    window_check(sn, inc, p_status, p_gap);
    exp.status = typed ? t_status : p_status;
    exp.gap    = typed ? t_gap : p_gap;
    expected_reports.push_back(exp);
    n_sent++;
  endtask

  task automatic source_pause();
    int n;
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // sink side: random ready bursts
  initial begin
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        out_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // report checker
  always @(posedge clk_i) begin : check_reports
    report_t exp;
    if (rst_ni && out_if.valid && out_if.ready) begin
      case (out_if.data.status)
        STATUS_OK:      n_ok++;
        STATUS_REORDER: n_reorder++;
        STATUS_MISSED:  n_missed++;
        default: ;
      endcase
      if (expected_reports.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected report status=%0d gap=%0d", $realtime,
                   out_if.data.status, out_if.data.gap);
      end else begin
        exp = expected_reports.pop_front();
        n_checked++;
        if (out_if.data.status !== exp.status || out_if.data.gap !== exp.gap) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: report %0d: expected status=%0d gap=%0d, got status=%0d gap=%0d",
                     $realtime, n_checked, exp.status, exp.gap,
                     out_if.data.status, out_if.data.gap);
        end
      end
    end
  end

  initial begin
    logic [31:0] last_sn;
    logic [31:0] step;
    logic [31:0] sn;
    logic [31:0] inc;
    seq_kind_e   kind;
    int          waited;
    hist_last   = 0;
    foreach (hist_ring[i]) hist_ring[i] = '0;
    n_sent      = 0;
    n_checked   = 0;
    n_mismatch  = 0;
    n_ok        = 0;
    n_reorder   = 0;
    n_missed    = 0;
    stalls_on   = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    stalls_on = 1'b1;
    foreach (dir_rows[i]) begin
      source_pause();
      send_packet(dir_rows[i].seq, dir_rows[i].inc, dir_rows[i].typed,
                  dir_rows[i].status, dir_rows[i].gap);
    end

    last_sn = $urandom;
    step    = $urandom_range(1, 20);
    for (int i = 0; i < N_RANDOM; i++) begin
      stalls_on = (i % 200) < 160 && i < N_RANDOM - N_CALM;
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 3))
          0:       step = $urandom;
          1:       step = DEPTH * $urandom_range(0, 3);
          default: step = $urandom_range(1, 20);
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kind = KIND_NEXT;
        6:                kind = KIND_SKIP;
        7:                kind = KIND_REPEAT;
        default:          kind = KIND_WILD;
      endcase
      inc = step;
      case (kind)
        KIND_NEXT:   sn = last_sn + step;
        KIND_SKIP:   sn = last_sn + step * $urandom_range(2, 6);
        KIND_REPEAT: sn = last_sn - step * $urandom_range(0, 8);
        default: begin
          sn = $urandom;
          if ($urandom_range(0, 1) == 1) inc = $urandom;
        end
      endcase
      last_sn = sn;
      source_pause();
      send_packet(sn, inc, 1'b0, STATUS_OK, 32'sd0);
    end
    stalls_on = 1'b0;
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    waited = 0;
    while (expected_reports.size() != 0) begin
      @(posedge clk_i);
      waited++;
      if (waited > 5000) begin
        $display("%0d reports never arrived", expected_reports.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
    repeat (50) @(posedge clk_i);

    $display("%0d packets sent (%0d from table), %0d reports checked", n_sent,
             N_DIRECTED, n_checked);
    $display("reports seen: %0d in order, %0d reordered, %0d missed, %0d mismatches",
             n_ok, n_reorder, n_missed, n_mismatch);
    if (n_mismatch == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
